### rtl/infix_to_postfix_converter_defines.svh
// Assertion macros used by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled during reset.
`define I2P_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define I2P_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2P_ASSERT(label, clk, rst, prop, msg)
`define I2P_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/i2p_pkg.sv
// Character codes, status codes and character classes for the converter.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_Z      = 8'h7A;

  localparam logic [2:0] RANK_NONE = 3'd0;
  localparam logic [2:0] RANK_ADD  = 3'd4;
  localparam logic [2:0] RANK_MUL  = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNMATCHED = 2'd2;

  // byte address of the stack limit register
  localparam logic [1:0] ADDR_STACK_LIMIT = 2'd0;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACE);
  endfunction

  function automatic logic [2:0] rank_of(input logic [7:0] c);
    logic [2:0] r;
    r = RANK_NONE;
    if ((c == CH_STAR) || (c == CH_SLASH)) r = RANK_MUL;
    else if ((c == CH_PLUS) || (c == CH_MINUS)) r = RANK_ADD;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter with a memory-held operator stack.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | request   | in_valid/in_stall   | symbol, end_of_expr
//  out     | result    | out_valid/out_stall | symbol_out, has_symbol, last, status
//  cfg     | APB write | psel/penable/pready | stack_limit at byte address 0
//
// Letters, openers and ignored characters need only the dispatch state. An operator or closer
// adds an evaluation state per stack entry examined, read from the registered stack memory.
// An end-marked item adds the flush state, an evaluation per leftover entry and the end state.
// A stalled output holds the sequencer in place until the register drains.
// Reset clears the stack count, status and output valid; the stack memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           symbol,
  input  wire logic                 end_of_expr,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                symbol_out,
  output logic                      has_symbol,
  output logic                      last,
  output i2p_pkg::status_t          status,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [1:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = (CW > 6) ? CW : 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  localparam logic [1:0] M_OPER  = 2'd0;
  localparam logic [1:0] M_CLOSE = 2'd1;
  localparam logic [1:0] M_FLUSH = 2'd2;

  logic [7:0]    op_stack [STACK_DEPTH];
  logic [7:0]    rdata;

  logic [2:0]    state, state_next;
  logic [1:0]    mode, mode_next;
  logic [CW-1:0] count, count_next;
  status_t       err, err_next;
  logic [5:0]    stack_limit;
  logic [7:0]    cur_sym;
  logic          cur_end;
  logic [7:0]    pend, pend_next;
  logic          pend_v, pend_v_next;

  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wa;
  logic          push_req, emit_req, out_load;
  logic [CW-1:0] push_pos;
  logic [7:0]    emit_sym;
  status_t       err_new;
  logic [7:0]    out_sym_d;
  logic          out_has_d, out_last_d;
  status_t       out_stat_d;

  logic          can_emit;
  logic [CW-1:0] cnt_m1, cnt_m2, eff_lim;
  logic [LW-1:0] lim_w;
  logic [2:0]    fin_state;
  logic          top_open;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STACK_LIMIT) ? {26'd0, stack_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= 6'd32;
    end else if (psel && penable && pwrite && pready) begin
      stack_limit <= pwdata[5:0];
    end
  end

  always_comb begin
    lim_w = LW'(stack_limit);
    if (stack_limit == 6'd0) eff_lim = CW'(1);
    else if (lim_w > LW'(STACK_DEPTH)) eff_lim = CW'(STACK_DEPTH);
    else eff_lim = CW'(lim_w);
  end

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign can_emit  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign fin_state = cur_end ? S_FLUSH : S_IDLE;
  assign top_open  = is_opener(rdata);

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) op_stack[wa] <= cur_sym;
    if (rd_en) rdata <= op_stack[rd_addr];
  end

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    count_next  = count;
    err_next    = err;
    pend_next   = pend;
    pend_v_next = pend_v;
    rd_en       = 1'b0;
    rd_addr     = cnt_m1[AW-1:0];
    we          = 1'b0;
    wa          = '0;
    push_req    = 1'b0;
    push_pos    = count;
    emit_req    = 1'b0;
    emit_sym    = cur_sym;
    err_new     = ST_OK;
    out_load    = 1'b0;
    out_sym_d   = 8'd0;
    out_has_d   = 1'b1;
    out_last_d  = 1'b0;
    out_stat_d  = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        if (is_letter(cur_sym)) begin
          emit_req = 1'b1;
          if (can_emit) state_next = fin_state;
        end else if (is_opener(cur_sym)) begin
          push_req   = 1'b1;
          state_next = fin_state;
        end else if (rank_of(cur_sym) != RANK_NONE) begin
          if (count == '0) begin
            push_req   = 1'b1;
            state_next = fin_state;
          end else begin
            rd_en      = 1'b1;
            mode_next  = M_OPER;
            state_next = S_EVAL;
          end
        end else if (is_closer(cur_sym)) begin
          if (count == '0) begin
            err_new    = ST_UNMATCHED;
            state_next = fin_state;
          end else begin
            rd_en      = 1'b1;
            mode_next  = M_CLOSE;
            state_next = S_EVAL;
          end
        end else begin
          state_next = fin_state;
        end
      end
      S_EVAL: begin
        emit_sym = rdata;
        case (mode)
          M_OPER: begin
            if (top_open || (rank_of(rdata) < rank_of(cur_sym))) begin
              push_req   = 1'b1;
              state_next = fin_state;
            end else begin
              emit_req = 1'b1;
              if (can_emit) begin
                count_next = cnt_m1;
                if (count == CW'(1)) begin
                  push_req   = 1'b1;
                  push_pos   = '0;
                  state_next = fin_state;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_m2[AW-1:0];
                end
              end
            end
          end
          M_CLOSE: begin
            if (top_open) begin
              count_next = cnt_m1;
              state_next = fin_state;
            end else begin
              emit_req = 1'b1;
              if (can_emit) begin
                count_next = cnt_m1;
                if (count == CW'(1)) begin
                  err_new    = ST_UNMATCHED;
                  state_next = fin_state;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_m2[AW-1:0];
                end
              end
            end
          end
          M_FLUSH: begin
            // leftover openers are dropped without output
            emit_req = !top_open;
            if (top_open || can_emit) begin
              count_next = cnt_m1;
              if (count == CW'(1)) begin
                state_next = S_END;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cnt_m2[AW-1:0];
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FLUSH: begin
        if (count != '0) begin
          rd_en      = 1'b1;
          mode_next  = M_FLUSH;
          state_next = S_EVAL;
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        if (can_emit) begin
          out_load    = 1'b1;
          out_sym_d   = pend_v ? pend : 8'd0;
          out_has_d   = pend_v;
          out_last_d  = 1'b1;
          out_stat_d  = err;
          pend_v_next = 1'b0;
          count_next  = '0;
          err_next    = ST_OK;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (push_req) begin
      if (push_pos >= eff_lim) begin
        err_new    = ST_OVERFLOW;
        count_next = push_pos;
      end else begin
        we         = 1'b1;
        wa         = push_pos[AW-1:0];
        count_next = push_pos + CW'(1);
      end
    end

    // in an end-marked item one character is held back so last can ride on it
    if (emit_req && can_emit) begin
      if (cur_end) begin
        pend_next   = emit_sym;
        pend_v_next = 1'b1;
        out_load    = pend_v;
        out_sym_d   = pend;
      end else begin
        out_load  = 1'b1;
        out_sym_d = emit_sym;
      end
    end

    if ((err_new != ST_OK) && (err == ST_OK)) err_next = err_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mode   <= M_OPER;
      count  <= '0;
      err    <= ST_OK;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      mode   <= mode_next;
      count  <= count_next;
      err    <= err_next;
      pend_v <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (state == S_IDLE && in_valid) begin
      cur_sym <= symbol;
      cur_end <= end_of_expr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      symbol_out <= out_sym_d;
      has_symbol <= out_has_d;
      last       <= out_last_d;
      status     <= out_stat_d;
    end
  end

  `I2P_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")
  `I2P_ASSERT(a_count_in_range, clk, rst, count <= CW'(STACK_DEPTH), "stack count over depth")
  `I2P_ASSERT(a_no_rw_overlap, clk, rst,
              !(rd_en && we && (rd_addr == wa)), "stack read/write collide")
  `I2P_ASSERT(a_end_clears, clk, rst,
              (state == S_END && can_emit) |=> (count == '0 && err == ST_OK && !pend_v),
              "end did not clear stack state")
  `I2P_ASSERT(a_status_on_last, clk, rst,
              (out_valid && !last) |-> (status == ST_OK && has_symbol),
              "status or bare marker off last")

endmodule

`default_nettype wire
